/* src/dgds_pkg.sv */
// ----------------------------------------------------------------------------
// Direction grid package
// Shared widths, codes, word types and states of the direction grid builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dgds_pkg;

   localparam int VALUE_W            = 24;
   localparam int CNT_W              = 5;
   localparam int TOL_W              = 16;
   localparam int STORE_MAX          = 16;
   localparam int GRID_DEPTH_DEFAULT = 16;

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

   localparam logic KIND_ADD     = 1'b0;
   localparam logic KIND_EMIT    = 1'b1;
   localparam logic AXIS_AZIMUTH = 1'b0;
   localparam logic AXIS_COSINE  = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] azimuth_value;
      logic signed [VALUE_W-1:0] cosine_value;
   } req_word_type;

   typedef struct packed {
      logic                      axis;
      logic signed [VALUE_W-1:0] grid_value;
      logic [CNT_W-1:0]          position;
      logic                      empty_res;
      logic                      overflow;
      logic                      last;
   } rsp_word_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SORT  = 5'b00100,
      S_SEND  = 5'b01000,
      S_EMPTY = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* src/dgds_req_if.sv */
// ----------------------------------------------------------------------------
// Direction grid request channel
// Valid/ready channel that carries one add or emit word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dgds_req_if import dgds_pkg::*; ();

   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* src/dgds_rsp_if.sv */
// ----------------------------------------------------------------------------
// Direction grid response channel
// Valid/ready channel that carries one sorted grid word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dgds_rsp_if import dgds_pkg::*; ();

   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* src/direction_grid_dedup_sort.sv */
// ----------------------------------------------------------------------------
// Direction grid de-duplicate and sort
// Keeps tolerance-unique azimuth and cosine values and emits both grids in
// ascending order on request.
//
//   Channel  Direction  Handshake          Word
//   req_ch   in         valid / ready      kind, azimuth_value, cosine_value
//   rsp_ch   out        valid / ready      axis, grid_value, position, flags
//   csr      in         csr_wr_en          match_tolerance
//
// An add word walks at most Na + Nc entries, where Na and Nc are the stored
// counts, with one subtract and compare unit that walks the grid memory an entry
// a cycle. An emit word needs a full selection pass over a grid of N entries
// for each output word.
// The block takes no new word until the current one is finished. The output
// register lets the last response wait while the next request is accepted.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module direction_grid_dedup_sort import dgds_pkg::*; #(
   parameter int GRID_DEPTH = GRID_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [TOL_W-1:0] csr_wr_data,
   dgds_req_if.sink              req_ch,
   dgds_rsp_if.source            rsp_ch
);

   localparam int GRID_CAP = (GRID_DEPTH > STORE_MAX) ? STORE_MAX :
                             ((GRID_DEPTH < 1) ? 1 : GRID_DEPTH);
   localparam int IDX_W    = (GRID_CAP > 1) ? $clog2(GRID_CAP) : 1;
   localparam int SLOT_NUM = 1 << IDX_W;
   localparam int ADDR_W   = IDX_W + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(GRID_CAP);

   state_type                state_ff, state_in;
   logic [TOL_W-1:0]         tol_ff, tol_in;
   logic [CNT_W-1:0]         az_cnt_ff, az_cnt_in;
   logic [CNT_W-1:0]         cos_cnt_ff, cos_cnt_in;
   logic                     ovf_ff, ovf_in;
   logic                     axis_ff, axis_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic                     match_ff, match_in;
   logic [VALUE_W-1:0]       az_val_ff, az_val_in;
   logic [VALUE_W-1:0]       cos_val_ff, cos_val_in;
   logic [VALUE_W-1:0]       best_ff, best_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic                     have_best_ff, have_best_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [SLOT_NUM-1:0]      used_ff, used_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [VALUE_W-1:0]       grid_mem [2*SLOT_NUM];
   logic [VALUE_W-1:0]       rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [VALUE_W-1:0]       wr_data;

   logic [CNT_W-1:0]         cur_cnt;
   logic [CNT_W-1:0]         pos_nxt;
   logic [VALUE_W-1:0]       operand;
   logic [VALUE_W:0]         diff;
   logic [VALUE_W:0]         mag;
   logic                     hit;
   logic                     less;
   logic                     issue;
   logic                     scan_done;
   logic                     sort_done;
   logic                     out_free;
   logic                     accept;
   logic                     load_out;
   rsp_word_type             out_word;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign accept         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;
   assign out_free       = !rsp_valid_ff || rsp_ch.ready;

   assign cur_cnt = (axis_ff == AXIS_COSINE) ? cos_cnt_ff : az_cnt_ff;
   assign pos_nxt = pos_ff + CNT_W'(1);
   assign rd_addr = {axis_ff, idx_ff[IDX_W-1:0]};

   // Shared subtract and compare unit.
   assign operand = (state_ff == S_SCAN) ?
                    ((axis_ff == AXIS_COSINE) ? cos_val_ff : az_val_ff) : best_ff;
   assign diff    = {rd_data_ff[VALUE_W-1], rd_data_ff} - {operand[VALUE_W-1], operand};
   assign mag     = diff[VALUE_W] ? (~diff + (VALUE_W+1)'(1)) : diff;
   assign hit     = (mag <= {{(VALUE_W+1-TOL_W){1'b0}}, tol_ff});
   assign less    = diff[VALUE_W];

   assign issue     = (((state_ff == S_SCAN) && !match_ff) || (state_ff == S_SORT)) &&
                      (idx_ff < cur_cnt);
   assign scan_done = match_ff || ((idx_ff >= cur_cnt) && !pend_ff);
   assign sort_done = (idx_ff >= cur_cnt) && !pend_ff;

   always_comb begin
      state_in     = state_ff;
      az_cnt_in    = az_cnt_ff;
      cos_cnt_in   = cos_cnt_ff;
      ovf_in       = ovf_ff;
      axis_in      = axis_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      match_in     = match_ff;
      az_val_in    = az_val_ff;
      cos_val_in   = cos_val_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      have_best_in = have_best_ff;
      pos_in       = pos_ff;
      used_in      = used_ff;
      wr_en        = 1'b0;
      wr_addr      = {axis_ff, cur_cnt[IDX_W-1:0]};
      wr_data      = operand;
      load_out     = 1'b0;

      out_word.axis       = axis_ff;
      out_word.grid_value = best_ff;
      out_word.position   = pos_ff;
      out_word.empty_res  = 1'b0;
      out_word.overflow   = ovf_ff;
      out_word.last       = (pos_nxt == cur_cnt) &&
                            ((axis_ff == AXIS_COSINE) || (cos_cnt_ff == '0));

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in  = '0;
               pend_in = 1'b0;
               if (req_ch.payload.kind == KIND_ADD) begin
                  az_val_in  = req_ch.payload.azimuth_value;
                  cos_val_in = req_ch.payload.cosine_value;
                  axis_in    = AXIS_AZIMUTH;
                  match_in   = 1'b0;
                  state_in   = S_SCAN;
               end else if ((az_cnt_ff == '0) && (cos_cnt_ff == '0)) begin
                  state_in = S_EMPTY;
               end else begin
                  axis_in      = (az_cnt_ff == '0) ? AXIS_COSINE : AXIS_AZIMUTH;
                  pos_in       = '0;
                  have_best_in = 1'b0;
                  used_in      = '0;
                  state_in     = S_SORT;
               end
            end
         end
         S_SCAN: begin
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff && hit) begin
               match_in = 1'b1;
            end
            if (scan_done) begin
               pend_in = 1'b0;
               if (!match_ff) begin
                  if (cur_cnt >= CAP_CNT) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     if (axis_ff == AXIS_COSINE) begin
                        cos_cnt_in = cos_cnt_ff + CNT_W'(1);
                     end else begin
                        az_cnt_in = az_cnt_ff + CNT_W'(1);
                     end
                  end
               end
               if (axis_ff == AXIS_AZIMUTH) begin
                  axis_in  = AXIS_COSINE;
                  idx_in   = '0;
                  match_in = 1'b0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SORT: begin
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff && !used_ff[pend_idx_ff] && (!have_best_ff || less)) begin
               best_in      = rd_data_ff;
               best_idx_in  = pend_idx_ff;
               have_best_in = 1'b1;
            end
            if (sort_done) begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (out_free) begin
               load_out              = 1'b1;
               used_in[best_idx_ff]  = 1'b1;
               pos_in                = pos_nxt;
               idx_in                = '0;
               pend_in               = 1'b0;
               have_best_in          = 1'b0;
               if (pos_nxt < cur_cnt) begin
                  state_in = S_SORT;
               end else if ((axis_ff == AXIS_AZIMUTH) && (cos_cnt_ff != '0)) begin
                  axis_in  = AXIS_COSINE;
                  pos_in   = '0;
                  used_in  = '0;
                  state_in = S_SORT;
               end else begin
                  az_cnt_in  = '0;
                  cos_cnt_in = '0;
                  ovf_in     = 1'b0;
                  state_in   = S_IDLE;
               end
            end
         end
         S_EMPTY: begin
            out_word.axis       = AXIS_AZIMUTH;
            out_word.grid_value = '0;
            out_word.position   = '0;
            out_word.empty_res  = 1'b1;
            out_word.last       = 1'b1;
            if (out_free) begin
               load_out = 1'b1;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      tol_in       = csr_wr_en ? csr_wr_data : tol_ff;
      rsp_word_in  = load_out ? out_word : rsp_word_ff;
      rsp_valid_in = load_out ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= TOL_RESET;
         az_cnt_ff    <= '0;
         cos_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         match_ff     <= 1'b0;
         have_best_ff <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         az_cnt_ff    <= az_cnt_in;
         cos_cnt_ff   <= cos_cnt_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         match_ff     <= match_in;
         have_best_ff <= have_best_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      az_val_ff   <= az_val_in;
      cos_val_ff  <= cos_val_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      pos_ff      <= pos_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (az_cnt_ff <= CAP_CNT) && (cos_cnt_ff <= CAP_CNT))
      else $error("A grid count exceeds the grid capacity.");

   a_send_has_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND) |-> have_best_ff)
      else $error("A sorted word is sent without a selected entry.");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (load_out && out_word.last) |=>
      ((az_cnt_ff == '0) && (cos_cnt_ff == '0) && !ovf_ff))
      else $error("The grids are not cleared after the last word.");

endmodule

`default_nettype wire
